// ----- rtl/core/prd_pkg.sv -----
// Shared types and constants of the readout event decoder.
`default_nettype none

package prd_pkg;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 19;
  localparam int HELD_W  = 14;
  localparam int REG_W   = 5;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int EVN_W   = 32;
  localparam int TIME_W  = 64;
  localparam int POS_W   = 24;
  localparam int KIND_W  = 2;
  localparam int ERR_W   = 3;
  localparam int MASK_W  = 8;
  localparam int IDX_W   = 4;
  localparam int OUT_W   = 144;
  localparam int CFG_W   = 24;
  localparam int CFGI_W  = 1;

  // Zero fill at the top of the result data, up to a whole byte.
  localparam int PAD_W   = OUT_W - ERR_W - COL_W - ROW_W - EVN_W - TIME_W - POS_W;

  // Command queue between the parser and the result sequencer.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_START_OFFSET = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_EMIT_SHORT   = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_HEADER    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_FRAME     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_WORD      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TRAILER   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd5;

  // Stream byte values.
  localparam logic [BYTE_W-1:0] EVT_HEADER_BYTE  = 8'hAA;
  localparam logic [BYTE_W-1:0] EVT_TRAILER_BYTE = 8'hBB;
  localparam logic [BYTE_W-1:0] IDLE_BYTE        = 8'hFF;
  localparam logic [3:0]        NIB_EMPTY        = 4'hE;
  localparam logic [3:0]        NIB_CHIP_HDR     = 4'hA;
  localparam logic [3:0]        NIB_CHIP_TRL     = 4'hB;
  localparam logic [2:0]        REGION_HDR_TOP   = 3'b110;
  localparam logic [1:0]        LONG_WORD_TOP    = 2'b00;
  localparam logic [1:0]        SHORT_WORD_TOP   = 2'b01;

  // Byte counts of the fixed-length fields.
  localparam logic [IDX_W-1:0] HDR_LEN   = 4'd4;
  localparam logic [IDX_W-1:0] EVN_LEN   = 4'd4;
  localparam logic [IDX_W-1:0] TIME_LEN  = 4'd8;
  localparam logic [IDX_W-1:0] EMPTY_LEN = 4'd3;
  localparam logic [IDX_W-1:0] TRL_LEN   = 4'd4;

  // What the parser hands to the result sequencer for one byte.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_HIT,
    OP_MAP,
    OP_EVENT,
    OP_ERROR
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ERR_W-1:0]    err;
    logic [ADDR_W-1:0]   addr;
    logic [MASK_W-1:0]   mask;
    logic                eob_err;
    logic [EVN_W-1:0]    evn;
    logic [TIME_W-1:0]   tstamp;
    logic [POS_W-1:0]    endp;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/prd_front.sv -----
// Byte parser: walks the event format and issues at most one command per byte.
`default_nettype none

module prd_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [prd_pkg::BYTE_W-1:0]     s_tdata,
  input  wire logic                           s_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [prd_pkg::CFGI_W-1:0]     cfg_index,
  input  wire logic [prd_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           q_full,
  output logic                                push,
  output prd_pkg::cmd_t                       cmd
);

  typedef enum logic [3:0] {
    PH_HDR, PH_EVN, PH_TIME, PH_FRAME, PH_EMPTY, PH_CHIPSKIP, PH_CHIP,
    PH_LONG1, PH_LONG2, PH_SHORT1, PH_PAD, PH_TRL
  } phase_t;

  phase_t                          phase, phase_next;
  logic [prd_pkg::IDX_W-1:0]       idx, idx_next, idx_inc;
  logic [prd_pkg::EVN_W-1:0]       evn, evn_next;
  logic [prd_pkg::TIME_W-1:0]      ts, ts_next;
  logic [prd_pkg::REG_W-1:0]       region, region_next;
  logic [prd_pkg::HELD_W-1:0]      held, held_next;
  logic [prd_pkg::POS_W-1:0]       position, pos_inc;
  logic [prd_pkg::POS_W-1:0]       start_offset;
  logic                            emit_short;
  logic                            accept;
  logic [prd_pkg::BYTE_W-1:0]      b;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign idx_inc  = idx + 4'd1;
  assign pos_inc  = position + 24'd1;

  // Parse one byte: next parser state and the command it causes.
  always_comb begin
    phase_next  = phase;
    idx_next    = idx;
    evn_next    = evn;
    ts_next     = ts;
    region_next = region;
    held_next   = held;
    cmd         = '0;
    cmd.op      = prd_pkg::OP_NONE;

    unique case (phase)
      PH_HDR: begin
        if (b != prd_pkg::EVT_HEADER_BYTE) begin
          cmd.op  = prd_pkg::OP_ERROR;
          cmd.err = prd_pkg::ERR_HEADER;
          idx_next = '0;
        end else begin
          if (idx == '0) begin
            region_next = '0;
          end
          idx_next = idx_inc;
          if (idx_inc >= prd_pkg::HDR_LEN) begin
            phase_next = PH_EVN;
            idx_next   = '0;
            evn_next   = '0;
          end
        end
      end
      PH_EVN: begin
        evn_next[idx[1:0]*8 +: 8] = b;
        idx_next = idx_inc;
        if (idx_inc >= prd_pkg::EVN_LEN) begin
          phase_next = PH_TIME;
          idx_next   = '0;
          ts_next    = '0;
        end
      end
      PH_TIME: begin
        ts_next[idx[2:0]*8 +: 8] = b;
        idx_next = idx_inc;
        if (idx_inc >= prd_pkg::TIME_LEN) begin
          phase_next = PH_FRAME;
          idx_next   = '0;
        end
      end
      PH_FRAME: begin
        if (b[7:4] == prd_pkg::NIB_EMPTY) begin
          phase_next = PH_EMPTY;
          idx_next   = '0;
        end else if (b[7:4] == prd_pkg::NIB_CHIP_HDR) begin
          phase_next = PH_CHIPSKIP;
        end else begin
          cmd.op     = prd_pkg::OP_ERROR;
          cmd.err    = prd_pkg::ERR_FRAME;
          phase_next = PH_HDR;
          idx_next   = '0;
        end
      end
      PH_EMPTY: begin
        idx_next = idx_inc;
        if (idx_inc >= prd_pkg::EMPTY_LEN) begin
          phase_next = PH_TRL;
          idx_next   = '0;
        end
      end
      PH_CHIPSKIP: begin
        phase_next = PH_CHIP;
      end
      PH_CHIP: begin
        if (b[7:6] == prd_pkg::LONG_WORD_TOP) begin
          held_next  = {b[5:0], 8'h00};
          phase_next = PH_LONG1;
        end else if (b[7:6] == prd_pkg::SHORT_WORD_TOP) begin
          held_next  = {b[5:0], 8'h00};
          phase_next = PH_SHORT1;
        end else if (b[7:5] == prd_pkg::REGION_HDR_TOP) begin
          region_next = b[4:0];
        end else if (b[7:4] == prd_pkg::NIB_CHIP_TRL) begin
          // Go straight to the event trailer when already aligned.
          if (pos_inc[1:0] == 2'b00) begin
            phase_next = PH_TRL;
            idx_next   = '0;
          end else begin
            phase_next = PH_PAD;
          end
        end else if (b == prd_pkg::IDLE_BYTE) begin
          phase_next = phase;
        end else begin
          cmd.op     = prd_pkg::OP_ERROR;
          cmd.err    = prd_pkg::ERR_WORD;
          phase_next = PH_HDR;
          idx_next   = '0;
        end
      end
      PH_LONG1: begin
        held_next  = {held[13:8], b};
        cmd.op     = prd_pkg::OP_HIT;
        cmd.addr   = {region, held[13:8], b};
        phase_next = PH_LONG2;
      end
      PH_LONG2: begin
        if (b != '0) begin
          cmd.op   = prd_pkg::OP_MAP;
          cmd.addr = {region, held};
          cmd.mask = b;
        end
        phase_next = PH_CHIP;
      end
      PH_SHORT1: begin
        held_next = {held[13:8], b};
        if (emit_short) begin
          cmd.op   = prd_pkg::OP_HIT;
          cmd.addr = {region, held[13:8], b};
        end
        phase_next = PH_CHIP;
      end
      PH_PAD: begin
        if (pos_inc[1:0] == 2'b00) begin
          phase_next = PH_TRL;
          idx_next   = '0;
        end
      end
      PH_TRL: begin
        if (b != prd_pkg::EVT_TRAILER_BYTE) begin
          cmd.op     = prd_pkg::OP_ERROR;
          cmd.err    = prd_pkg::ERR_TRAILER;
          phase_next = PH_HDR;
          idx_next   = '0;
        end else begin
          idx_next = idx_inc;
          if (idx_inc >= prd_pkg::TRL_LEN) begin
            cmd.op     = prd_pkg::OP_EVENT;
            cmd.evn    = evn;
            cmd.tstamp = ts;
            cmd.endp   = pos_inc;
            phase_next = PH_HDR;
            idx_next   = '0;
          end
        end
      end
      default: begin
        phase_next = PH_HDR;
        idx_next   = '0;
      end
    endcase

    // The buffer ends: an open event is reported as truncated.
    if (s_tlast) begin
      cmd.eob_err = (phase_next != PH_HDR) || (idx_next != '0);
      phase_next  = PH_HDR;
      idx_next    = '0;
    end
  end

  assign push = accept && ((cmd.op != prd_pkg::OP_NONE) || cmd.eob_err);

  // Parser state, position counter and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR;
      idx          <= '0;
      evn          <= '0;
      ts           <= '0;
      region       <= '0;
      held         <= '0;
      position     <= '0;
      start_offset <= '0;
      emit_short   <= 1'b0;
    end else begin
      if (accept) begin
        phase    <= phase_next;
        idx      <= idx_next;
        evn      <= evn_next;
        ts       <= ts_next;
        region   <= region_next;
        held     <= held_next;
        position <= s_tlast ? start_offset : pos_inc;
      end
      if (cfg_we) begin
        if (cfg_index == prd_pkg::CFG_START_OFFSET) begin
          start_offset <= cfg_data;
          position     <= cfg_data;
        end else begin
          emit_short <= cfg_data[0];
        end
      end
    end
  end

  // The last byte of a buffer always leaves the parser waiting for a header.
  a_eob_closes: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> (phase == PH_HDR) && (idx == '0))
    else $error("parser left open after end of buffer");

  // The byte index stays below the length of the longest field, the time stamp.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx < prd_pkg::TIME_LEN)
    else $error("byte index out of range");

endmodule

`default_nettype wire

// ----- rtl/core/prd_cmd_fifo.sv -----
// Short command queue between the parser and the result sequencer.
`default_nettype none

module prd_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire prd_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output prd_pkg::cmd_t      head,
  output logic               full,
  output logic               empty
);

  prd_pkg::cmd_t                    entries [prd_pkg::QDEPTH];
  logic [prd_pkg::QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [prd_pkg::QCNT_W-1:0]       count;

  function automatic logic [prd_pkg::QCNT_W-1:0] QCNT_ONE(input logic v);
    QCNT_ONE = {{(prd_pkg::QCNT_W-1){1'b0}}, v};
  endfunction

  assign full  = (count == prd_pkg::QCNT_W'(prd_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == prd_pkg::QPTR_W'(prd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == prd_pkg::QPTR_W'(prd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_ONE(push) - QCNT_ONE(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("command queue underflow");

endmodule

`default_nettype wire

// ----- rtl/core/prd_back.sv -----
// Result sequencer: expands each command into beats, one per ready cycle.
`default_nettype none

module prd_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire prd_pkg::cmd_t                q_cmd,
  input  wire logic                         q_empty,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [prd_pkg::OUT_W-1:0]         m_tdata,
  output logic [prd_pkg::KIND_W-1:0]        m_tuser,
  output logic                              m_tlast
);

  // Result data layout, lowest bits last in the list.
  typedef struct packed {
    logic [prd_pkg::PAD_W-1:0]   pad;
    logic [prd_pkg::POS_W-1:0]   endp;
    logic [prd_pkg::TIME_W-1:0]  tstamp;
    logic [prd_pkg::EVN_W-1:0]   evn;
    logic [prd_pkg::ROW_W-1:0]   row;
    logic [prd_pkg::COL_W-1:0]   col;
    logic [prd_pkg::ERR_W-1:0]   err;
  } beat_t;

  prd_pkg::cmd_t                 cur;
  logic                          cur_valid;
  logic                          main_pend;
  logic                          eob_pend;
  logic [prd_pkg::MASK_W-1:0]    mask;
  logic [prd_pkg::MASK_W-1:0]    mask_after;
  logic                          eob_after;
  logic [2:0]                    bit_k;
  logic [prd_pkg::ADDR_W-1:0]    hit_addr;
  beat_t                         beat;
  logic [prd_pkg::KIND_W-1:0]    beat_kind;
  logic                          beat_last;
  logic                          advance;
  logic                          emit;

  // Lowest set bit of the remaining hitmap.
  always_comb begin
    bit_k = '0;
    for (int i = prd_pkg::MASK_W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        bit_k = 3'(i);
      end
    end
  end

  // Form the next beat of the current command.
  always_comb begin
    beat      = '0;
    beat_kind = prd_pkg::KIND_HIT;
    hit_addr  = cur.addr;
    if (main_pend) begin
      case (cur.op)
        prd_pkg::OP_EVENT: begin
          beat_kind   = prd_pkg::KIND_EVENT;
          beat.evn    = cur.evn;
          beat.tstamp = cur.tstamp;
          beat.endp   = cur.endp;
        end
        prd_pkg::OP_ERROR: begin
          beat_kind = prd_pkg::KIND_ERROR;
          beat.err  = cur.err;
        end
        default: begin
          beat_kind = prd_pkg::KIND_HIT;
        end
      endcase
    end else if (mask != '0) begin
      hit_addr  = cur.addr + prd_pkg::ADDR_W'(bit_k) + prd_pkg::ADDR_W'(1);
      beat_kind = prd_pkg::KIND_HIT;
    end else begin
      beat_kind = prd_pkg::KIND_ERROR;
      beat.err  = prd_pkg::ERR_TRUNCATED;
    end
    if (beat_kind == prd_pkg::KIND_HIT) begin
      beat.col = {hit_addr[18:10], hit_addr[0] ^ hit_addr[1]};
      beat.row = hit_addr[9:1];
    end
  end

  // What is left of the command after this beat.
  always_comb begin
    mask_after = main_pend ? mask : (mask & (mask - 8'd1));
    eob_after  = (main_pend || (mask != '0)) ? eob_pend : 1'b0;
    beat_last  = (mask_after == '0) && !eob_after;
  end

  assign advance = !m_tvalid || m_tready;
  assign emit    = advance && cur_valid;
  assign q_pop   = !q_empty && (!cur_valid || (emit && beat_last));

  // Current command and its remaining work.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      main_pend <= 1'b0;
      eob_pend  <= 1'b0;
      mask      <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      main_pend <= (q_cmd.op == prd_pkg::OP_HIT) || (q_cmd.op == prd_pkg::OP_EVENT) ||
                   (q_cmd.op == prd_pkg::OP_ERROR);
      mask      <= (q_cmd.op == prd_pkg::OP_MAP) ? q_cmd.mask : '0;
      eob_pend  <= q_cmd.eob_err;
    end else if (emit) begin
      main_pend <= 1'b0;
      mask      <= mask_after;
      eob_pend  <= eob_after;
      if (beat_last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= beat;
      m_tuser <= beat_kind;
      m_tlast <= beat_last;
    end
  end

  // A command held here always has at least one beat still to send.
  a_work_left: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (main_pend || (mask != '0) || eob_pend))
    else $error("empty command held in sequencer");

  // A finished command releases the sequencer unless the next one is loaded.
  a_release: assert property (@(posedge clk) disable iff (rst)
    emit && beat_last && q_empty |=> !cur_valid)
    else $error("sequencer kept a finished command");

endmodule

`default_nettype wire

// ----- rtl/core/pixel_readout_event_decoder.sv -----
// Top level of the readout event decoder: parser, command queue and sequencer.
//
// The decoder accepts one readout byte per clock as long as its four-entry
// command queue has room, and sends one result beat per clock while m_tready
// is high; results leave through an output register. Most bytes cause at
// most one result; the hitmap byte of a long data word causes one hit per
// set bit, up to eight, plus a truncation error when it is also the last
// byte of the buffer, so a run of such bytes fills the queue and input ready
// drops until the sequencer frees an entry. There is no clearing pass after
// reset. Configuration must be written only while the decoder is idle;
// the block does not enforce it. Writing start_offset reloads the position.
`default_nettype none

module pixel_readout_event_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input beats.
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [prd_pkg::BYTE_W-1:0]   s_tdata,  // data_byte[7:0]
  input  wire logic                         s_tlast,  // end_of_buffer
  // Result beats.
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // error_code[2:0], column[12:3], row[21:13], event_number[53:22],
  // event_time[117:54], end_position[141:118], zero fill[143:142]
  output logic [prd_pkg::OUT_W-1:0]         m_tdata,
  output logic [prd_pkg::KIND_W-1:0]        m_tuser,  // kind[1:0]
  output logic                              m_tlast,  // last_of_run
  // Configuration writes.
  input  wire logic                         cfg_we,
  input  wire logic [prd_pkg::CFGI_W-1:0]   cfg_index,
  input  wire logic [prd_pkg::CFG_W-1:0]    cfg_data
);

  prd_pkg::cmd_t push_cmd;
  prd_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  prd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  prd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  prd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_cmd    (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
